### sv/vqda_pkg.sv
`timescale 1ns / 1ps

package vqda_pkg;

    // Table geometry; the index fields are 8 bits wide, so the table holds 256 entries
    localparam int QUEUE_DEPTH  = 256;
    localparam int IDX_W        = $clog2(QUEUE_DEPTH);
    localparam int SIZE_W       = IDX_W + 1;
    localparam int GROUP_W      = 32;
    localparam int GROUPS       = QUEUE_DEPTH / GROUP_W;
    localparam int GRP_W        = $clog2(GROUPS);
    localparam int BIT_W        = $clog2(GROUP_W);
    localparam int TRIPLE_COUNT = 3;
    localparam int CNT_W        = $clog2(TRIPLE_COUNT + 1);

    localparam logic [1:0] ACT_ALLOC_ONE   = 2'd0;
    localparam logic [1:0] ACT_ALLOC_THREE = 2'd1;
    localparam logic [1:0] ACT_SET_LINK    = 2'd2;
    localparam logic [1:0] ACT_RELEASE     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_WAS_FREE  = 2'd3;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] entry_index;
        logic [IDX_W-1:0] next_index;
        logic             link_valid;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  desc_index;
        logic [1:0]        status;
        logic [SIZE_W-1:0] freed_count;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic             has_next;
        logic [IDX_W-1:0] next;
    } link_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_WALK_CHECK,
        S_WALK_READ,
        S_EMIT
    } state_t;

    function automatic logic [GRP_W-1:0] lowest_group(input logic [GROUPS-1:0] v);
        logic [GRP_W-1:0] r;
        r = '0;
        for (int i = GROUPS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = GRP_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [BIT_W-1:0] lowest_bit(input logic [GROUP_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = GROUP_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### sv/virtqueue_descriptor_allocator.sv
`timescale 1ns / 1ps
// Channel  | Signals                     | Direction | Transaction when
// request  | req_valid, req_stall, req   | in        | req_valid & !req_stall
// response | rsp_valid, rsp_stall, rsp   | out       | rsp_valid & !rsp_stall
// config   | cfg_valid, cfg_ready, cfg_data | in     | cfg_valid & cfg_ready
//
// One request at a time; req_stall is high from acceptance until its last result is
// loaded into the output register. Allocation builds a group summary, then makes a priority
// pick, for each entry; set_link writes the link RAM on acceptance. Releasing a chain
// checks and then reads each link walked, paced by the registered read of the link RAM.
// Reset frees every entry and marks every link unwritten at once; no clearing pass.
// A stall on the response side holds the result register and delays the next emit only.

module virtqueue_descriptor_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  vqda_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output vqda_pkg::rsp_t              rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [vqda_pkg::SIZE_W-1:0] cfg_data
);

    localparam int IDX_W  = vqda_pkg::IDX_W;
    localparam int SIZE_W = vqda_pkg::SIZE_W;
    localparam int DEPTH  = vqda_pkg::QUEUE_DEPTH;
    localparam int GROUPS = vqda_pkg::GROUPS;
    localparam int GRP_W  = vqda_pkg::GRP_W;
    localparam int BIT_W  = vqda_pkg::BIT_W;
    localparam int GW     = vqda_pkg::GROUP_W;
    localparam int CNT_W  = vqda_pkg::CNT_W;
    localparam int TRI    = vqda_pkg::TRIPLE_COUNT;

    vqda_pkg::state_t state_reg, state_next;

    logic [SIZE_W-1:0] queue_size_reg;
    logic [DEPTH-1:0]  free_map_reg, free_map_next;
    logic [DEPTH-1:0]  link_vld_reg, link_vld_next;
    logic [GROUPS-1:0] group_reg, group_next;
    logic [1:0]        action_reg, action_next;
    logic [IDX_W-1:0]  entry_reg, entry_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [SIZE_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0]  taken_reg, taken_next;
    logic              multi_reg, multi_next;
    logic [IDX_W-1:0]  got_reg [TRI];
    logic [IDX_W-1:0]  got_next [TRI];
    vqda_pkg::rsp_t    res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    vqda_pkg::rsp_t    rsp_reg, rsp_next;

    logic [SIZE_W-1:0] eff_size;
    logic              req_fire;
    logic              out_free;
    logic [GROUPS-1:0] group_any;
    logic [GRP_W-1:0]  pick_grp;
    logic [GW-1:0]     pick_word;
    logic [BIT_W-1:0]  pick_bit;
    logic [IDX_W-1:0]  cand;
    logic              found;
    logic              ram_wr_en;
    vqda_pkg::link_t   ram_rd_data;
    vqda_pkg::link_t   link_cur;

    assign eff_size  = (queue_size_reg > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : queue_size_reg;
    assign req_stall = (state_reg != vqda_pkg::S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_any[g] = |free_map_reg[g*GW +: GW];
        end
    end

    // Lowest free entry overall; it lies inside the queue only if below the size
    assign pick_grp  = vqda_pkg::lowest_group(group_reg);
    assign pick_word = free_map_reg[{pick_grp, {BIT_W{1'b0}}} +: GW];
    assign pick_bit  = vqda_pkg::lowest_bit(pick_word);
    assign cand      = {pick_grp, pick_bit};
    assign found     = (|group_reg) && ({1'b0, cand} < eff_size);

    assign ram_wr_en = req_fire && (req.action == vqda_pkg::ACT_SET_LINK)
                       && ({1'b0, req.entry_index} < eff_size);

    vqda_ram #(
        .WIDTH ($bits(vqda_pkg::link_t)),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (req.entry_index),
        .wr_data ({req.link_valid, req.next_index}),
        .rd_addr (cur_reg),
        .rd_data (ram_rd_data)
    );

    // An unwritten or cleared link reads as zero
    assign link_cur = link_vld_reg[cur_reg] ? ram_rd_data : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vqda_pkg::S_IDLE;
            queue_size_reg <= SIZE_W'(DEPTH);
            free_map_reg   <= '1;
            link_vld_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            taken_reg      <= '0;
            multi_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_map_reg  <= free_map_next;
            link_vld_reg  <= link_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            taken_reg     <= taken_next;
            multi_reg     <= multi_next;
            if (cfg_valid && cfg_ready)
            begin
                queue_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg  <= group_next;
        action_reg <= action_next;
        entry_reg  <= entry_next;
        cur_reg    <= cur_next;
        count_reg  <= count_next;
        got_reg    <= got_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        free_map_next  = free_map_reg;
        link_vld_next  = link_vld_reg;
        group_next     = group_reg;
        action_next    = action_reg;
        entry_next     = entry_reg;
        cur_next       = cur_reg;
        count_next     = count_reg;
        taken_next     = taken_reg;
        multi_next     = multi_reg;
        got_next       = got_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            vqda_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    action_next = req.action;
                    entry_next  = req.entry_index;
                    cur_next    = req.entry_index;
                    count_next  = '0;
                    taken_next  = '0;
                    multi_next  = 1'b0;
                    case (req.action)
                        vqda_pkg::ACT_SET_LINK:
                        begin
                            res_next.desc_index  = req.entry_index;
                            res_next.freed_count = '0;
                            res_next.last        = 1'b1;
                            if (ram_wr_en)
                            begin
                                res_next.status = vqda_pkg::ST_OK;
                                link_vld_next[req.entry_index] = 1'b1;
                            end
                            else
                            begin
                                res_next.status = vqda_pkg::ST_RANGE;
                            end
                            state_next = vqda_pkg::S_EMIT;
                        end
                        vqda_pkg::ACT_RELEASE:
                        begin
                            state_next = vqda_pkg::S_WALK_CHECK;
                        end
                        default:
                        begin
                            state_next = vqda_pkg::S_SCAN;
                        end
                    endcase
                end
            end

            vqda_pkg::S_SCAN:
            begin
                group_next = group_any;
                state_next = vqda_pkg::S_PICK;
            end

            vqda_pkg::S_PICK:
            begin
                res_next.freed_count = '0;
                res_next.last        = 1'b1;
                if (found)
                begin
                    free_map_next[cand] = 1'b0;
                    if (action_reg == vqda_pkg::ACT_ALLOC_ONE)
                    begin
                        res_next.desc_index = cand;
                        res_next.status     = vqda_pkg::ST_OK;
                        state_next          = vqda_pkg::S_EMIT;
                    end
                    else
                    begin
                        got_next[taken_reg] = cand;
                        taken_next = taken_reg + 1'b1;
                        if (taken_reg == CNT_W'(TRI - 1))
                        begin
                            multi_next = 1'b1;
                            state_next = vqda_pkg::S_EMIT;
                        end
                        else
                        begin
                            state_next = vqda_pkg::S_SCAN;
                        end
                    end
                end
                else
                begin
                    // Give back whatever this request already took
                    for (int j = 0; j < TRI - 1; j++)
                    begin
                        if (CNT_W'(j) < taken_reg)
                        begin
                            free_map_next[got_reg[j]] = 1'b1;
                        end
                    end
                    res_next.desc_index = '0;
                    res_next.status     = vqda_pkg::ST_NO_FREE;
                    state_next          = vqda_pkg::S_EMIT;
                end
            end

            vqda_pkg::S_WALK_CHECK:
            begin
                res_next.desc_index  = cur_reg;
                res_next.freed_count = count_reg;
                res_next.last        = 1'b1;
                if ({1'b0, cur_reg} >= eff_size)
                begin
                    res_next.status = vqda_pkg::ST_RANGE;
                    state_next      = vqda_pkg::S_EMIT;
                end
                else if (free_map_reg[cur_reg])
                begin
                    res_next.status = vqda_pkg::ST_WAS_FREE;
                    state_next      = vqda_pkg::S_EMIT;
                end
                else
                begin
                    state_next = vqda_pkg::S_WALK_READ;
                end
            end

            vqda_pkg::S_WALK_READ:
            begin
                free_map_next[cur_reg] = 1'b1;
                link_vld_next[cur_reg] = 1'b0;
                count_next = count_reg + 1'b1;
                if (link_cur.has_next)
                begin
                    cur_next   = link_cur.next;
                    state_next = vqda_pkg::S_WALK_CHECK;
                end
                else
                begin
                    res_next.desc_index  = entry_reg;
                    res_next.status      = vqda_pkg::ST_OK;
                    res_next.freed_count = count_reg + 1'b1;
                    res_next.last        = 1'b1;
                    state_next           = vqda_pkg::S_EMIT;
                end
            end

            vqda_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (multi_reg)
                    begin
                        // Shift the taken entries out lowest first
                        rsp_next.desc_index  = got_reg[0];
                        rsp_next.status      = vqda_pkg::ST_OK;
                        rsp_next.freed_count = '0;
                        rsp_next.last        = (taken_reg == CNT_W'(1));
                        for (int j = 0; j < TRI - 1; j++)
                        begin
                            got_next[j] = got_reg[j+1];
                        end
                        taken_next = taken_reg - 1'b1;
                        if (taken_reg == CNT_W'(1))
                        begin
                            multi_next = 1'b0;
                            state_next = vqda_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        rsp_next   = res_reg;
                        state_next = vqda_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = vqda_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### sv/vqda_ram.sv
`timescale 1ns / 1ps

module vqda_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/vqda_checker.sv
`timescale 1ns / 1ps

module vqda_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input vqda_pkg::rsp_t rsp
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // One request at a time: the block stalls right after taking one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in progress");

    // Only alloc_three gives non-final results, each a successful allocation
    a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.status == vqda_pkg::ST_OK && rsp.freed_count == '0)
        else $error("non-final result is not a plain allocation");

    // A failed allocation names no entry and frees nothing
    a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == vqda_pkg::ST_NO_FREE
        |-> rsp.desc_index == '0 && rsp.freed_count == '0 && rsp.last)
        else $error("malformed no-free result");

endmodule

bind virtqueue_descriptor_allocator vqda_checker u_vqda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
